/* design/vva_pkg.sv */
// Shared types, opcode and status codes, and saturation helper for the vector ALU.
package vva_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 2;
    localparam int WIDE          = 67;

    localparam logic [3:0] OP_SUM    = 4'd0;
    localparam logic [3:0] OP_DIFF   = 4'd1;
    localparam logic [3:0] OP_NEG    = 4'd2;
    localparam logic [3:0] OP_SCALE  = 4'd3;
    localparam logic [3:0] OP_SUMMUL = 4'd4;
    localparam logic [3:0] OP_DOT    = 4'd5;
    localparam logic [3:0] OP_CROSS  = 4'd6;
    localparam logic [3:0] OP_SQMAG  = 4'd7;
    localparam logic [3:0] OP_MAG    = 4'd8;
    localparam logic [3:0] OP_NORM   = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] factor;
    } vva_in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar_out;
        logic [1:0]         status;
    } vva_out_t;

    typedef struct packed {
        logic is_iter;
        logic is_norm;
    } vva_ctrl_t;

    typedef struct packed {
        vva_in_t   item;
        vva_ctrl_t ctrl;
    } vva_entry_t;

    typedef struct packed {
        logic             start;
        logic             is_norm;
        logic [63:0]      sq;
        logic [2:0][31:0] mag;
    } vva_iter_req_t;

    typedef struct packed {
        logic             done;
        logic [31:0]      root;
        logic [2:0][31:0] quo;
        logic [2:0]       rem_nz;
    } vva_iter_rsp_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } vva_clamp_t;

    localparam logic signed [WIDE-1:0] MAX32 = 67'sd2147483647;
    localparam logic signed [WIDE-1:0] MIN32 = -67'sd2147483648;

    function automatic vva_clamp_t sat32(input logic signed [WIDE-1:0] v);
        vva_clamp_t c;
        if (v > MAX32)
        begin
            c.val = 32'sh7fffffff;
            c.sat = 1'b1;
        end
        else if (v < MIN32)
        begin
            c.val = 32'sh80000000;
            c.sat = 1'b1;
        end
        else
        begin
            c.val = v[31:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

/* design/vec3_vector_alu_core.sv */
// Top level of the three-component fixed-point vector ALU.
// Opcodes 0 to 7 pass the front, queue, execute and output registers.
// Magnitude adds a bit-serial square root, one result bit a cycle.
// Normalize adds the root, then a three-lane restoring divide.
// Throughput: one item per cycle for opcodes 0 to 7 unless the output stalls; the root
// unit holds the execute slot. Reset clears control state only; no memory clearing pass.
module vec3_vector_alu_core #(
    parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  vva_pkg::vva_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output vva_pkg::vva_out_t rsp
);
    import vva_pkg::*;

    logic       f_valid;
    logic       f_ready;
    vva_entry_t f_entry;
    logic       x_valid;
    logic       x_ready;
    vva_entry_t x_entry;

    vva_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_entry   (f_entry)
    );

    vva_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_entry (f_entry),
        .rd_valid (x_valid),
        .rd_ready (x_ready),
        .rd_entry (x_entry)
    );

    vva_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (x_valid),
        .q_ready   (x_ready),
        .q_entry   (x_entry),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* design/vva_front.sv */
// Front stage: registers incoming items and classifies them by opcode.
module vva_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  vva_pkg::vva_in_t    req,
    output logic                q_valid,
    input  logic                q_ready,
    output vva_pkg::vva_entry_t q_entry
);
    import vva_pkg::*;

    logic       valid_reg;
    vva_entry_t entry_reg;
    vva_ctrl_t  ctrl;

    always_comb
    begin
        ctrl = '0;
        unique case (req.opcode) inside
            OP_MAG:  ctrl.is_iter = 1'b1;
            OP_NORM:
            begin
                ctrl.is_iter = 1'b1;
                ctrl.is_norm = 1'b1;
            end
            default: ctrl = '0;
        endcase
    end

    assign req_ready = !valid_reg || q_ready;
    assign q_valid   = valid_reg;
    assign q_entry   = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req_ready)
            valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            entry_reg.item <= req;
            entry_reg.ctrl <= ctrl;
        end
    end

endmodule

/* design/vva_queue.sv */
// Short queue between the front and execute stages.
module vva_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  vva_pkg::vva_entry_t wr_entry,
    output logic                rd_valid,
    input  logic                rd_ready,
    output vva_pkg::vva_entry_t rd_entry
);
    import vva_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    vva_entry_t    mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push;
    logic          pop;

    assign wr_ready = cnt_reg != CW'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

/* design/vva_iter.sv */
// Bit-serial square root and three-lane divider for magnitude and normalize.
module vva_iter #(
    parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vva_pkg::vva_iter_req_t req,
    input  logic                   ack,
    output vva_pkg::vva_iter_rsp_t rsp
);
    import vva_pkg::*;

    localparam int NW   = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(NW);

    typedef enum logic [3:0] {
        IT_IDLE = 4'b0001,
        IT_SQRT = 4'b0010,
        IT_DIV  = 4'b0100,
        IT_DONE = 4'b1000
    } it_state_t;

    it_state_t       state_reg;
    it_state_t       state_next;
    logic [CNTW-1:0] cnt_reg;
    logic            norm_reg;
    logic [63:0]     rad_reg;
    logic [31:0]     srem_reg;
    logic [31:0]     root_reg;
    logic [NW-1:0]   num_reg  [3];
    logic [31:0]     drem_reg [3];

    logic [33:0]     s_cur;
    logic [33:0]     s_trial;
    logic            s_take;
    logic [31:0]     root_nx;
    logic [32:0]     d_cur  [3];
    logic            d_take [3];

    assign s_cur   = {srem_reg, rad_reg[63:62]};
    assign s_trial = {root_reg, 2'b01};
    assign s_take  = s_cur >= s_trial;
    assign root_nx = {root_reg[30:0], s_take};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_cur[i]  = {drem_reg[i], num_reg[i][NW-1]};
            d_take[i] = d_cur[i] >= {1'b0, root_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IT_IDLE: if (req.start) state_next = IT_SQRT;
            IT_SQRT:
                if (cnt_reg == CNTW'(31))
                    state_next = (norm_reg && root_nx != '0) ? IT_DIV : IT_DONE;
            IT_DIV:  if (cnt_reg == CNTW'(NW - 1)) state_next = IT_DONE;
            IT_DONE: if (ack) state_next = IT_IDLE;
            default: state_next = IT_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == IT_IDLE)
        begin
            norm_reg <= req.is_norm;
            rad_reg  <= req.sq;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (state_reg == IT_SQRT)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            srem_reg <= s_take ? 32'(s_cur - s_trial) : s_cur[31:0];
            root_reg <= root_nx;
            // load dividends as the root settles
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]  <= {req.mag[i], {FRAC_BITS{1'b0}}};
                drem_reg[i] <= '0;
            end
        end
        else if (state_reg == IT_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]  <= {num_reg[i][NW-2:0], d_take[i]};
                drem_reg[i] <= d_take[i] ? 32'(d_cur[i] - {1'b0, root_reg}) : d_cur[i][31:0];
            end
        end
    end

    always_comb
    begin
        rsp.done = state_reg == IT_DONE;
        rsp.root = root_reg;
        for (int i = 0; i < 3; i++)
        begin
            rsp.quo[i]    = num_reg[i][31:0];
            rsp.rem_nz[i] = drem_reg[i] != '0;
        end
    end

endmodule

/* design/vva_back.sv */
// Execute stage: products, sums, rounding, saturation and the output register.
module vva_back #(
    parameter int FRAC_BITS = vva_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  vva_pkg::vva_entry_t q_entry,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output vva_pkg::vva_out_t   rsp
);
    import vva_pkg::*;

    logic               s1_valid_reg;
    vva_entry_t         s1_reg;
    logic signed [63:0] pa_reg [3];
    logic signed [63:0] pb_reg [3];
    logic               o_valid_reg;
    vva_out_t           o_reg;

    logic signed [31:0] qa [3];
    logic signed [31:0] qb [3];
    logic signed [31:0] ma [3];
    logic signed [31:0] mb [3];
    logic signed [31:0] na [3];
    logic signed [31:0] nb [3];
    logic signed [31:0] sa [3];
    logic signed [31:0] sb [3];

    logic signed [WIDE-1:0] wv [3];
    logic signed [WIDE-1:0] ws;
    logic signed [WIDE-1:0] psum;
    logic signed [WIDE-1:0] qw [3];
    logic signed [WIDE-1:0] qc [3];
    vva_clamp_t         cv [3];
    vva_clamp_t         cs;
    logic               zero_err;
    vva_out_t           res;

    vva_iter_req_t      it_req;
    vva_iter_rsp_t      it_rsp;
    logic               out_free;
    logic               retire;

    assign qa[0] = q_entry.item.a_x;
    assign qa[1] = q_entry.item.a_y;
    assign qa[2] = q_entry.item.a_z;
    assign qb[0] = q_entry.item.b_x;
    assign qb[1] = q_entry.item.b_y;
    assign qb[2] = q_entry.item.b_z;

    // multiplier operand select
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma[i] = qa[i];
            mb[i] = qb[i];
            na[i] = qa[i];
            nb[i] = qb[i];
        end
        case (q_entry.item.opcode) inside
            OP_SCALE:
                for (int i = 0; i < 3; i++) mb[i] = q_entry.item.factor;
            OP_SUMMUL:
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = qb[i];
                    mb[i] = q_entry.item.factor;
                end
            OP_CROSS:
            begin
                ma[0] = qa[1]; mb[0] = qb[2]; na[0] = qa[2]; nb[0] = qb[1];
                ma[1] = qa[2]; mb[1] = qb[0]; na[1] = qa[0]; nb[1] = qb[2];
                ma[2] = qa[0]; mb[2] = qb[1]; na[2] = qa[1]; nb[2] = qb[0];
            end
            OP_SQMAG, OP_MAG, OP_NORM:
                for (int i = 0; i < 3; i++) mb[i] = qa[i];
            default: ;
        endcase
    end

    assign out_free = !o_valid_reg || rsp_ready;
    assign retire   = s1_valid_reg && out_free && (!s1_reg.ctrl.is_iter || it_rsp.done);
    assign q_ready  = !s1_valid_reg || retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_ready)
                s1_valid_reg <= q_valid;
            if (out_free)
                o_valid_reg <= retire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            s1_reg <= q_entry;
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= ma[i] * mb[i];
                pb_reg[i] <= na[i] * nb[i];
            end
        end
        if (retire)
            o_reg <= res;
    end

    assign sa[0] = s1_reg.item.a_x;
    assign sa[1] = s1_reg.item.a_y;
    assign sa[2] = s1_reg.item.a_z;
    assign sb[0] = s1_reg.item.b_x;
    assign sb[1] = s1_reg.item.b_y;
    assign sb[2] = s1_reg.item.b_z;

    always_comb
    begin
        it_req.start   = s1_valid_reg && s1_reg.ctrl.is_iter;
        it_req.is_norm = s1_reg.ctrl.is_norm;
        it_req.sq      = pa_reg[0] + pa_reg[1] + pa_reg[2];
        for (int i = 0; i < 3; i++)
            it_req.mag[i] = sa[i][31] ? 32'(-sa[i]) : sa[i];
    end

    vva_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (it_req),
        .ack   (retire),
        .rsp   (it_rsp)
    );

    assign psum = WIDE'(pa_reg[0]) + WIDE'(pa_reg[1]) + WIDE'(pa_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qw[i] = $signed({35'd0, it_rsp.quo[i]});
            qc[i] = qw[i] + $signed({66'd0, it_rsp.rem_nz[i]});
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++) wv[i] = '0;
        ws       = '0;
        zero_err = 1'b0;
        case (s1_reg.item.opcode) inside
            OP_SUM:
                for (int i = 0; i < 3; i++) wv[i] = WIDE'(sa[i]) + WIDE'(sb[i]);
            OP_DIFF:
                for (int i = 0; i < 3; i++) wv[i] = WIDE'(sa[i]) - WIDE'(sb[i]);
            OP_NEG:
                for (int i = 0; i < 3; i++) wv[i] = -WIDE'(sa[i]);
            OP_SCALE:
                for (int i = 0; i < 3; i++) wv[i] = WIDE'(pa_reg[i]) >>> FRAC_BITS;
            OP_SUMMUL:
                for (int i = 0; i < 3; i++)
                    wv[i] = WIDE'(sa[i]) + (WIDE'(pa_reg[i]) >>> FRAC_BITS);
            OP_DOT, OP_SQMAG:
                ws = psum >>> FRAC_BITS;
            OP_CROSS:
                for (int i = 0; i < 3; i++)
                    wv[i] = (WIDE'(pa_reg[i]) - WIDE'(pb_reg[i])) >>> FRAC_BITS;
            OP_MAG:
                ws = $signed({35'd0, it_rsp.root});
            OP_NORM:
                if (it_rsp.root == '0)
                    zero_err = 1'b1;
                else
                    for (int i = 0; i < 3; i++)
                        wv[i] = sa[i][31] ? -qc[i] : qw[i];
            default: ;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++) cv[i] = sat32(wv[i]);
        cs             = sat32(ws);
        res.r_x        = cv[0].val;
        res.r_y        = cv[1].val;
        res.r_z        = cv[2].val;
        res.scalar_out = cs.val;
        if (zero_err)
            res.status = ST_ZERO;
        else if (cv[0].sat || cv[1].sat || cv[2].sat || cs.sat)
            res.status = ST_SAT;
        else
            res.status = ST_OK;
    end

    assign rsp_valid = o_valid_reg;
    assign rsp       = o_reg;

    a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        retire |=> rsp_valid)
        else $error("retired item did not reach the output register");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_ZERO |->
            rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0 && rsp.scalar_out == '0)
        else $error("zero-vector normalize result carries nonzero fields");

    a_iter_owner: assert property (@(posedge clk) disable iff (!rst_n)
        it_rsp.done |-> s1_valid_reg && s1_reg.ctrl.is_iter)
        else $error("root unit finished without an owning item");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the fixed-point three-component vector ALU.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vva_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    vva_in_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    vva_out_t rsp;

    vva_out_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_recv = 1'b0;
    longint cycles = 0;

    vec3_vector_alu_core DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_q(longint x);
        return x >>> FB;
    endfunction

    function automatic logic signed [31:0] clamp(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // exact floor of a three-term product sum over 2^FB, in 67 bits, limited to +-2^62
    function automatic longint floor_sum3(longint p0, longint p1, longint p2);
        logic signed [66:0] s;
        s = 67'(signed'(p0)) + 67'(signed'(p1)) + 67'(signed'(p2));
        s = s >>> FB;
        if (s > 67'sd4611686018427387904)
            return 64'sd4611686018427387904;
        if (s < -67'sd4611686018427387904)
            return -64'sd4611686018427387904;
        return longint'(s);
    endfunction

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic vva_out_t alu_result(vva_in_t it);
        vva_out_t o;
        longint a[3];
        longint b[3];
        longint f;
        longint m;
        longint num;
        logic [63:0] sq;
        bit sat;
        o = '0;
        sat = 1'b0;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
        f = it.factor;
        case (it.opcode)
            OP_SUM:
            begin
                o.r_x = clamp(a[0] + b[0], sat);
                o.r_y = clamp(a[1] + b[1], sat);
                o.r_z = clamp(a[2] + b[2], sat);
            end
            OP_DIFF:
            begin
                o.r_x = clamp(a[0] - b[0], sat);
                o.r_y = clamp(a[1] - b[1], sat);
                o.r_z = clamp(a[2] - b[2], sat);
            end
            OP_NEG:
            begin
                o.r_x = clamp(-a[0], sat);
                o.r_y = clamp(-a[1], sat);
                o.r_z = clamp(-a[2], sat);
            end
            OP_SCALE:
            begin
                o.r_x = clamp(floor_q(a[0] * f), sat);
                o.r_y = clamp(floor_q(a[1] * f), sat);
                o.r_z = clamp(floor_q(a[2] * f), sat);
            end
            OP_SUMMUL:
            begin
                o.r_x = clamp(a[0] + floor_q(b[0] * f), sat);
                o.r_y = clamp(a[1] + floor_q(b[1] * f), sat);
                o.r_z = clamp(a[2] + floor_q(b[2] * f), sat);
            end
            OP_DOT:
                o.scalar_out = clamp(floor_sum3(a[0] * b[0], a[1] * b[1], a[2] * b[2]), sat);
            OP_CROSS:
            begin
                o.r_x = clamp(floor_sum3(a[1] * b[2], -(a[2] * b[1]), 0), sat);
                o.r_y = clamp(floor_sum3(a[2] * b[0], -(a[0] * b[2]), 0), sat);
                o.r_z = clamp(floor_sum3(a[0] * b[1], -(a[1] * b[0]), 0), sat);
            end
            OP_SQMAG:
                o.scalar_out = clamp(floor_sum3(a[0] * a[0], a[1] * a[1], a[2] * a[2]), sat);
            OP_MAG, OP_NORM:
            begin
                // sum of squares fits 64 unsigned bits (at most 3 * 2^62)
                sq = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
                m = int_sqrt(sq);
                if (it.opcode == OP_MAG)
                    o.scalar_out = clamp(m, sat);
                else if (m == 0)
                    o.status = ST_ZERO;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        num = a[i] * (64'sd1 <<< FB);
                        if (num >= 0)
                            num = num / m;
                        else
                            num = -((-num + m - 1) / m);
                        if (i == 0) o.r_x = clamp(num, sat);
                        if (i == 1) o.r_y = clamp(num, sat);
                        if (i == 2) o.r_z = clamp(num, sat);
                    end
                end
            end
            default: ;
        endcase
        if (o.status == ST_OK && sat)
            o.status = ST_SAT;
        return o;
    endfunction

    task automatic send_item(vva_in_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_q.push_back(alu_result(it));
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ready <= !hold_recv && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        vva_out_t e;
        cycles++;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp.r_x !== e.r_x)
                begin
                    $error("r_x expected %0d actual %0d", e.r_x, rsp.r_x); errors++;
                end
                if (rsp.r_y !== e.r_y)
                begin
                    $error("r_y expected %0d actual %0d", e.r_y, rsp.r_y); errors++;
                end
                if (rsp.r_z !== e.r_z)
                begin
                    $error("r_z expected %0d actual %0d", e.r_z, rsp.r_z); errors++;
                end
                if (rsp.scalar_out !== e.scalar_out)
                begin
                    $error("scalar_out expected %0d actual %0d", e.scalar_out, rsp.scalar_out);
                    errors++;
                end
                if (rsp.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, rsp.status); errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return signed'(32'($urandom_range(65535))) - 32'sd32768;
            3: return signed'($urandom) >>> $urandom_range(20, 8);
            default: return signed'($urandom);
        endcase
    endfunction

    function automatic vva_in_t rand_item();
        vva_in_t it;
        it.opcode = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp();
        it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp();
        it.factor = rand_comp();
        if (it.opcode == OP_NORM && $urandom_range(7) == 0)
        begin
            it.a_x = '0; it.a_y = '0; it.a_z = '0;
        end
        return it;
    endfunction

    function automatic vva_in_t make_item(logic [3:0] op, logic signed [31:0] av,
                                          logic signed [31:0] bv, logic signed [31:0] f);
        vva_in_t it;
        it.opcode = op;
        it.a_x = av; it.a_y = -av; it.a_z = av >>> 1;
        it.b_x = bv; it.b_y = bv; it.b_z = -bv;
        it.factor = f;
        return it;
    endfunction

    task automatic wait_drain();
        int guard;
        guard = 0;
        // drop valid once the last item is taken
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        // all results are in once the queue empties; let the clock run idle before the next test
        while (guard < 120)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic test_directed();
        for (int op = 0; op < 16; op++)
            send_item(make_item(4'(op), 32'sh00018000, 32'shfffe4000, 32'sh00020000));
        send_item(make_item(OP_NEG, 32'sh80000000, 0, 0));
        send_item(make_item(OP_SUM, 32'sh7fffffff, 32'sh7fffffff, 0));
        send_item(make_item(OP_SCALE, 32'sh80000000, 0, 32'sh80000000));
        send_item(make_item(OP_SUMMUL, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        send_item(make_item(OP_DOT, 32'sh80000000, 32'sh80000000, 0));
        send_item(make_item(OP_MAG, 32'sh80000000, 0, 0));
        send_item(make_item(OP_NORM, 0, 0, 0));
        send_item(make_item(OP_NORM, 32'shffffffff, 0, 0));
        send_item(make_item(OP_CROSS, 32'sh7fffffff, 32'sh80000000, 0));
        wait_drain();
    endtask

    task automatic test_random(int n, int sidle, int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n; i++)
            send_item(rand_item());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 1'b1;
        fork
            begin
                int k;
                k = 0;
                while (k < 200)
                begin
                    @(posedge clk);
                    k++;
                end
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_item(rand_item());
        join
        wait_drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(330, 37, 47);
        test_random(330, 47, 37);
        test_backpressure();
        test_random(330, 0, 0);
        wait_drain();
        $display("Sent %0d items over all ten opcodes plus undefined ones, checked %0d results,",
                 items_sent, results_seen);
        $display("with saturation, zero-vector normalize, random stalls and a long output hold.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* vec3_vector_alu_core.f */
design/vva_pkg.sv
design/vva_front.sv
design/vva_queue.sv
design/vva_iter.sv
design/vva_back.sv
design/vec3_vector_alu_core.sv
test/testbench.sv
